// ===== design/wdq_pkg.sv =====
// Package for the weight dequantizer: modes, state codes, block size and
// the FP16 to FP32 conversion. Used by wdq_mul, weight_dequantizer_top and the testbench.
package wdq_pkg;

  localparam int BlockWeights = 32;
  localparam int QaddrW = $clog2(BlockWeights);
  localparam int PhaseW = $clog2(BlockWeights + 2);
  localparam logic [31:0] CanonNan = 32'h7FC0_0000;

  typedef enum logic [1:0] {
    MODE_F32 = 2'd0,
    MODE_F16 = 2'd1,
    MODE_Q8  = 2'd2,
    MODE_OFF = 2'd3
  } mode_t;

  typedef enum logic [0:0] {
    ST_INTAKE = 1'b0,
    ST_EMIT   = 1'b1
  } state_t;

  localparam logic CfgIdxMode  = 1'b0;
  localparam logic CfgIdxCount = 1'b1;

  // Exact half to single conversion; exponent 31 gives signed infinity.
  function automatic logic [31:0] half_to_single(input logic [15:0] h);
    logic [4:0]  ex;
    logic [9:0]  man;
    logic [31:0] res;
    logic [3:0]  top;
    ex  = h[14:10];
    man = h[9:0];
    res = {h[15], 31'd0};
    top = 4'd0;
    if (ex == 5'h1F) begin
      res[30:23] = 8'hFF;
    end else if (ex != 5'd0) begin
      res[30:23] = {3'd0, ex} + 8'd112;
      res[22:13] = man;
    end else if (man != 10'd0) begin
      for (int i = 0; i < 10; i++) begin
        if (man[i]) top = 4'(i);
      end
      res[30:23] = {4'd0, top} + 8'd103;
      res[22:0]  = 23'({13'd0, man} << (5'd23 - {1'b0, top}));
    end
    return res;
  endfunction

endpackage

// ===== design/wdq_ram.sv =====
// Quant byte store: one write port, one registered read port with enable.
// Generic; no package use.
module wdq_ram #(
  parameter int Depth = 32,
  parameter int Width = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end
endmodule

// ===== design/wdq_mul.sv =====
// Quant times scale: an exact 8 by 24 bit product, then renormalized into
// a single. Uses wdq_pkg. One register stage inside, loaded when en is high.
module wdq_mul
  import wdq_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [7:0]  quant,
  input  logic [31:0] scale,
  output logic [31:0] prod
);
  logic        sgn, s_inf, q_zero;
  logic [7:0]  qmag;
  logic [23:0] smant;
  logic [8:0]  sexp;
  logic [31:0] m_r;
  logic [9:0]  e_r;
  logic        sgn_r, inf_r, zero_r, nan_r;
  logic [4:0]  lead;
  logic [31:0] norm;
  logic [9:0]  ex;

  always_comb begin
    qmag   = quant[7] ? 8'(-quant) : quant;
    sgn    = quant[7] ^ scale[31];
    s_inf  = scale[30:23] == 8'hFF;
    q_zero = quant == 8'd0;
    // Subnormal singles never come from a half, but keep it generic.
    smant  = {scale[30:23] != 8'd0, scale[22:0]};
    sexp   = (scale[30:23] == 8'd0) ? 9'd1 : {1'b0, scale[30:23]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_r    <= {8'd0, smant} * {24'd0, qmag};
      e_r    <= {1'b0, sexp};
      sgn_r  <= sgn;
      inf_r  <= s_inf;
      zero_r <= q_zero;
      nan_r  <= s_inf && q_zero;
    end
  end

  always_comb begin
    lead = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (m_r[i]) lead = 5'(i);
    end
    // Value is m * 2^(e-150); the leading one lands at bit 23.
    norm = (lead >= 5'd23) ? (m_r >> (lead - 5'd23)) : (m_r << (5'd23 - lead));
    ex   = e_r + {5'd0, lead} - 10'd23;
    if (nan_r)
      prod = CanonNan;
    else if (inf_r)
      prod = {sgn_r, 8'hFF, 23'd0};
    else if (zero_r || m_r == 32'd0)
      prod = {sgn_r, 31'd0};
    else
      prod = {sgn_r, ex[7:0], norm[22:0]};
  end
endmodule

// ===== design/weight_dequantizer_top.sv =====
// Weight dequantizer top level: control, gather, quant store and output.
// Uses wdq_pkg, wdq_ram and wdq_mul.
//
//  channel | direction | handshake        | payload
//  in_     | input     | in_valid/stall   | in_data_byte[7:0]
//  out_    | output    | out_valid/stall  | weight_bits, run_last, tensor_last
//  cfg_    | input     | cfg_wr_en        | cfg_index, cfg_wdata[31:0]
//
// F32 and F16 bytes are taken without a stall until a byte completes a word;
// intake then stalls while the word waits in the output register.
// A Q8_0 block of n weights takes n quant bytes and two scale bytes, then its
// n entries are read out through the RAM read register, the multiplier
// register and the output register. Intake stops during emission.
// Reset is synchronous and clears control state; quant store is not cleared.
// An output stall freezes the emission pipeline while the output register holds a word.
module weight_dequantizer_top
  import wdq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_weight_bits,
  output logic        out_run_last,
  output logic        out_tensor_last,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata
);
  mode_t        mode_r;
  logic [31:0]  count_r, done_r, done_nxt;
  logic [23:0]  gather_r, gather_nxt;
  logic [PhaseW-1:0] phase_r, phase_nxt;
  logic [7:0]   slow_r, slow_nxt;
  state_t       state_r, state_nxt;
  logic [31:0]  scale_r, scale_nxt;
  logic [PhaseW-1:0] blk_r, blk_nxt, ecnt_r, ecnt_nxt;
  // Emission pipeline: s1 = RAM read issued, s2 = product ready.
  logic         v1_r, v2_r, v1_nxt, v2_nxt;
  logic         l1_r, l2_r, l1_nxt, l2_nxt, t1_r, t2_r, t1_nxt, t2_nxt;
  logic         ov_r, ov_nxt, orl_r, orl_nxt, otl_r, otl_nxt;
  logic [31:0]  ow_r, ow_nxt;
  logic [7:0]   qrd;
  logic [31:0]  prod;
  logic         wr_en, acc, adv, fin;
  logic [31:0]  cnt, left;
  logic [PhaseW-1:0] blk;
  logic [31:0]  word;

  assign cnt  = (count_r == 32'd0) ? 32'd1 : count_r;
  assign left = (cnt > done_r) ? cnt - done_r : 32'd1;
  assign blk  = (left < 32'(BlockWeights)) ? PhaseW'(left) : PhaseW'(BlockWeights);
  assign acc  = in_valid && !in_stall;
  // The pipeline moves when the output register is free or being drained.
  assign adv  = !ov_r || !out_stall;

  assign in_stall = (state_r == ST_EMIT) || v1_r || v2_r || ov_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_F32;
      count_r <= 32'd1;
    end else if (cfg_wr_en) begin
      if (cfg_index == CfgIdxMode) mode_r <= mode_t'(cfg_wdata[1:0]);
      else count_r <= cfg_wdata;
    end
  end

  wdq_ram #(.Depth(BlockWeights), .Width(8)) u_ram (
    .clk(clk), .wr_en(wr_en), .wr_addr(phase_r[QaddrW-1:0]), .wr_data(in_data_byte),
    .rd_en(adv), .rd_addr(ecnt_r[QaddrW-1:0]), .rd_data(qrd)
  );

  wdq_mul u_mul (.clk(clk), .en(adv), .quant(qrd), .scale(scale_r), .prod(prod));

  always_comb begin
    state_nxt = state_r;  gather_nxt = gather_r; phase_nxt = phase_r;
    slow_nxt = slow_r;    done_nxt = done_r;     scale_nxt = scale_r;
    blk_nxt = blk_r;      ecnt_nxt = ecnt_r;
    v1_nxt = v1_r; v2_nxt = v2_r; l1_nxt = l1_r; l2_nxt = l2_r;
    t1_nxt = t1_r; t2_nxt = t2_r;
    ov_nxt = ov_r; ow_nxt = ow_r; orl_nxt = orl_r; otl_nxt = otl_r;
    wr_en = 1'b0;
    fin = left <= 32'd1;
    word = 32'd0;
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    unique case (state_r)
      ST_INTAKE: begin
        if (acc) begin
          unique case (mode_r)
            MODE_F32, MODE_F16: begin
              if (phase_r < ((mode_r == MODE_F32) ? PhaseW'(3) : PhaseW'(1))) begin
                gather_nxt = 24'({8'd0, gather_r} |
                             ({24'd0, in_data_byte} << {phase_r[1:0], 3'd0}));
                phase_nxt = phase_r + 1'b1;
              end else begin
                if (mode_r == MODE_F32) word = {in_data_byte, gather_r};
                else word = half_to_single({in_data_byte, gather_r[7:0]});
                ov_nxt = 1'b1; ow_nxt = word; orl_nxt = 1'b1; otl_nxt = fin;
                done_nxt = fin ? 32'd0 : done_r + 32'd1;
                gather_nxt = 24'd0; phase_nxt = '0;
              end
            end
            MODE_Q8: begin
              if (phase_r < blk) begin
                wr_en = 1'b1;
                phase_nxt = phase_r + 1'b1;
              end else if (phase_r == blk) begin
                slow_nxt = in_data_byte;
                phase_nxt = phase_r + 1'b1;
              end else begin
                scale_nxt = half_to_single({in_data_byte, slow_r});
                blk_nxt = blk; ecnt_nxt = '0;
                state_nxt = ST_EMIT;
                phase_nxt = '0; slow_nxt = 8'd0;
              end
            end
            default: ;
          endcase
        end
      end
      ST_EMIT: begin
        if (adv) begin
          // Issue read of entry ecnt_r; tensor end comes from the count.
          v1_nxt = 1'b1;
          t1_nxt = fin;
          l1_nxt = fin || (ecnt_r + 1'b1 == blk_r);
          done_nxt = fin ? 32'd0 : done_r + 32'd1;
          ecnt_nxt = ecnt_r + 1'b1;
          if (l1_nxt) state_nxt = ST_INTAKE;
        end
      end
      default: ;
    endcase
    if (adv) begin
      if (state_r != ST_EMIT) v1_nxt = 1'b0;
      v2_nxt = v1_r; l2_nxt = l1_r; t2_nxt = t1_r;
      if (v2_r) begin
        ov_nxt = 1'b1; ow_nxt = prod; orl_nxt = l2_r; otl_nxt = t2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INTAKE; gather_r <= '0; phase_r <= '0; slow_r <= '0;
      done_r <= '0; v1_r <= 1'b0; v2_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt; gather_r <= gather_nxt; phase_r <= phase_nxt;
      slow_r <= slow_nxt; done_r <= done_nxt; v1_r <= v1_nxt; v2_r <= v2_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scale_r <= scale_nxt; blk_r <= blk_nxt; ecnt_r <= ecnt_nxt;
    l1_r <= l1_nxt; l2_r <= l2_nxt; t1_r <= t1_nxt; t2_r <= t2_nxt;
    ow_r <= ow_nxt; orl_r <= orl_nxt; otl_r <= otl_nxt;
  end

  assign out_valid       = ov_r;
  assign out_weight_bits = ow_r;
  assign out_run_last    = orl_r;
  assign out_tensor_last = otl_r;
endmodule

// ===== design/wdq_checker.sv =====
// Port-level checks for the weight dequantizer.
// Bound to weight_dequantizer_top; uses only its ports.
module wdq_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_weight_bits,
  input logic        out_run_last,
  input logic        out_tensor_last
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_weight_bits))
    else $error("stalled word changed");
  a_tl_rl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_tensor_last |-> out_run_last)
    else $error("tensor end without run end");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("intake open while word pending");
  a_rst: assert property (@(posedge clk) $past(!rst_n) |-> !out_valid)
    else $error("word valid after reset");
endmodule

bind weight_dequantizer_top wdq_checker u_wdq_checker (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_weight_bits(out_weight_bits),
  .out_run_last(out_run_last), .out_tensor_last(out_tensor_last)
);

// ===== tb/sv/tb_weight_dequantizer_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for weight_dequantizer_top: a directed table, then random
// byte streams in all four modes. Depends on wdq_pkg and the RTL of the block.
module tb_weight_dequantizer_top;
  import wdq_pkg::*;

  localparam int CycleLimit = 2000000;
  localparam int SettleCycles = 60;
  localparam int ItemTarget = 330;

  typedef struct {
    logic [31:0] bits;
    logic        run_last;
    logic        tensor_last;
  } weight_t;

  typedef struct {
    logic        is_cfg;
    logic        idx;
    logic [31:0] val;
    logic        chk;
    logic [31:0] want;
  } row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_data_byte;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_weight_bits;
  logic        out_run_last;
  logic        out_tensor_last;
  logic        cfg_wr_en;
  logic        cfg_index;
  logic [31:0] cfg_wdata;

  // Shadow of the block's state.
  mode_t       sh_mode;
  logic [31:0] sh_count;
  logic [23:0] sh_gather;
  logic [5:0]  sh_phase;
  logic [7:0]  sh_quant [BlockWeights];
  logic [7:0]  sh_scale_lo;
  logic [31:0] sh_done;

  weight_t     pending_weights[$];
  row_t        dir_rows[$];
  int          errors;
  int          cycles;
  int          bytes_fed;
  int          weights_seen;
  bit          no_idle;

  weight_dequantizer_top DUT (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= 10) $display("ERROR at %0t: %s", $time, msg);
  endtask

  // Builds single-precision bits of (-1)^sgn * mag * 2^e; the value is exact and normal.
  function automatic logic [31:0] pack_single(input logic sgn, input int mag, input int e);
    real    r;
    logic [63:0] db;
    logic [10:0] dexp;
    r = mag;
    if (mag == 0) return {sgn, 31'd0};
    for (int i = 0; i < e; i++) r = r * 2.0;
    for (int i = 0; i > e; i--) r = r * 0.5;
    db = $realtobits(r);
    dexp = db[62:52] - 11'd896;
    return {sgn, dexp[7:0], db[51:29]};
  endfunction

  function automatic logic [31:0] half_bits_to_single(input logic [15:0] h);
    if (h[14:10] == 5'h1F) return {h[15], 8'hFF, 23'd0};
    if (h[14:10] == 5'd0) return pack_single(h[15], int'(h[9:0]), -24);
    return pack_single(h[15], int'(h[9:0]) + 1024, int'(h[14:10]) - 25);
  endfunction

  function automatic logic [31:0] scaled_quant(input logic [7:0] q, input logic [15:0] h);
    logic sgn;
    int   qa;
    sgn = q[7] ^ h[15];
    qa = q[7] ? 256 - int'(q) : int'(q);
    if (h[14:10] == 5'h1F) return (qa == 0) ? CanonNan : {sgn, 8'hFF, 23'd0};
    if (h[14:10] == 5'd0) return pack_single(sgn, qa * int'(h[9:0]), -24);
    return pack_single(sgn, qa * (int'(h[9:0]) + 1024), int'(h[14:10]) - 25);
  endfunction

  function automatic logic [31:0] weights_remaining();
    logic [31:0] cnt;
    cnt = (sh_count == 0) ? 32'd1 : sh_count;
    return (cnt > sh_done) ? cnt - sh_done : 32'd1;
  endfunction

  // Appends one weight; returns 1 when it closes the tensor.
  function automatic bit add_weight(ref weight_t rs[$], input logic [31:0] bits);
    weight_t w;
    bit fin;
    fin = weights_remaining() <= 1;
    w.bits = bits;
    w.run_last = 1'b0;
    w.tensor_last = fin;
    rs.push_back(w);
    sh_done = fin ? 32'd0 : sh_done + 1;
    return fin;
  endfunction

  task automatic dequantize_byte(input logic [7:0] b);
    weight_t     rs[$];
    logic [5:0]  last;
    logic [31:0] word;
    logic [31:0] blk;
    bit          fin;
    if (sh_mode == MODE_F32 || sh_mode == MODE_F16) begin
      last = (sh_mode == MODE_F32) ? 6'd3 : 6'd1;
      if (sh_phase < last) begin
        sh_gather = sh_gather | (24'(b) << (8 * sh_phase));
        sh_phase++;
      end else begin
        word = (32'(sh_gather) & ((32'd1 << (8 * last)) - 1)) | (32'(b) << (8 * last));
        fin = add_weight(rs, (sh_mode == MODE_F32) ? word : half_bits_to_single(word[15:0]));
        sh_gather = '0;
        sh_phase = '0;
      end
    end else if (sh_mode == MODE_Q8) begin
      blk = weights_remaining();
      if (blk > BlockWeights) blk = BlockWeights;
      if (sh_phase < blk) begin
        sh_quant[sh_phase] = b;
        sh_phase++;
      end else if (sh_phase == blk) begin
        sh_scale_lo = b;
        sh_phase++;
      end else begin
        fin = 0;
        for (int i = 0; i < blk && !fin; i++)
          fin = add_weight(rs, scaled_quant(sh_quant[i], {b, sh_scale_lo}));
        sh_phase = '0;
        sh_scale_lo = '0;
      end
    end
    if (rs.size() > 0) rs[rs.size() - 1].run_last = 1'b1;
    foreach (rs[i]) pending_weights.push_back(rs[i]);
  endtask

  task automatic feed_byte(input logic [7:0] b);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data_byte <= b;
    do @(posedge clk); while (in_stall);
    if (sh_mode != MODE_OFF) bytes_fed++;
    dequantize_byte(b);
  endtask

  // Waits for the block to drain, then writes one register.
  task automatic write_reg(input logic idx, input logic [31:0] val);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_weights.size() > 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CfgIdxMode) sh_mode = mode_t'(val[1:0]);
    else sh_count = val;
  endtask

  task automatic add_row(input logic is_cfg, input logic idx, input logic [31:0] val,
                         input logic chk, input logic [31:0] want);
    row_t r;
    r.is_cfg = is_cfg;
    r.idx = idx;
    r.val = val;
    r.chk = chk;
    r.want = want;
    dir_rows.push_back(r);
  endtask

  // Result side: random stall before each word, then check it.
  initial begin
    int stl;
    out_stall = 1'b1;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      stl = no_idle ? 0 : $urandom_range(0, 11);
      if (stl > 0) begin
        out_stall <= 1'b1;
        repeat (stl) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      weights_seen++;
      if (pending_weights.size() == 0) begin
        flag_error($sformatf("unexpected word %h", out_weight_bits));
      end else begin
        weight_t w;
        w = pending_weights.pop_front();
        if (w.bits !== out_weight_bits || w.run_last !== out_run_last ||
            w.tensor_last !== out_tensor_last)
          flag_error($sformatf("expected %h/%b/%b got %h/%b/%b", w.bits, w.run_last,
                               w.tensor_last, out_weight_bits, out_run_last,
                               out_tensor_last));
      end
    end
  end

  initial begin
    int          mode_pick;
    int          nbytes;
    logic [31:0] blk;
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data_byte = '0;
    cfg_wr_en = 1'b0;
    cfg_index = CfgIdxMode;
    cfg_wdata = '0;
    errors = 0;
    cycles = 0;
    bytes_fed = 0;
    weights_seen = 0;
    no_idle = 0;
    sh_mode = MODE_F32;
    sh_count = 32'd1;
    sh_gather = '0;
    sh_phase = '0;
    sh_scale_lo = '0;
    sh_done = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed table: infinities, NaN from infinity times zero, subnormal and
    // negative zero, count zero, ignored bytes, and a count lowered mid-tensor.
    add_row(0, 0, 8'h00, 0, 0);
    add_row(0, 0, 8'h00, 0, 0);
    add_row(0, 0, 8'h80, 0, 0);
    add_row(0, 0, 8'hFF, 1, 32'hFF80_0000);
    add_row(1, CfgIdxMode, MODE_F16, 0, 0);
    add_row(1, CfgIdxCount, 32'd0, 0, 0);
    add_row(0, 0, 8'h00, 0, 0);
    add_row(0, 0, 8'h7C, 1, 32'h7F80_0000);
    add_row(0, 0, 8'h01, 0, 0);
    add_row(0, 0, 8'hFC, 1, 32'hFF80_0000);
    add_row(0, 0, 8'h01, 0, 0);
    add_row(0, 0, 8'h00, 1, 32'h3380_0000);
    add_row(0, 0, 8'h00, 0, 0);
    add_row(0, 0, 8'h80, 1, 32'h8000_0000);
    add_row(1, CfgIdxMode, MODE_OFF, 0, 0);
    add_row(0, 0, 8'hAA, 0, 0);
    add_row(1, CfgIdxMode, MODE_Q8, 0, 0);
    add_row(1, CfgIdxCount, 32'd3, 0, 0);
    add_row(0, 0, 8'h7F, 0, 0);
    add_row(0, 0, 8'h80, 0, 0);
    add_row(0, 0, 8'h00, 0, 0);
    add_row(0, 0, 8'h00, 0, 0);
    add_row(0, 0, 8'h7C, 0, 0);
    add_row(1, CfgIdxMode, MODE_F32, 0, 0);
    add_row(1, CfgIdxCount, 32'hFFFF_FFFF, 0, 0);
    for (int i = 0; i < 4; i++) add_row(0, 0, 32'h3F << i, 0, 0);
    add_row(1, CfgIdxCount, 32'd1, 0, 0);
    for (int i = 0; i < 4; i++) add_row(0, 0, 8'hC1 + i, 0, 0);
    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        write_reg(dir_rows[i].idx, dir_rows[i].val);
      end else begin
        feed_byte(dir_rows[i].val[7:0]);
        if (dir_rows[i].chk && (pending_weights.size() == 0 ||
            pending_weights[pending_weights.size() - 1].bits !== dir_rows[i].want))
          flag_error($sformatf("table row %0d: predicted word is not %h", i,
                               dir_rows[i].want));
      end
    end

    // One full block so that every quant entry holds a written value.
    write_reg(CfgIdxMode, MODE_Q8);
    write_reg(CfgIdxCount, 32'd64);
    repeat (BlockWeights + 2) feed_byte($urandom_range(0, 255));

    while (bytes_fed < ItemTarget) begin
      no_idle = ($urandom_range(0, 4) == 0);
      mode_pick = $urandom_range(0, 9);
      write_reg(CfgIdxMode, (mode_pick < 3) ? MODE_F32 : (mode_pick < 6) ? MODE_F16 :
                            (mode_pick < 9) ? MODE_Q8 : MODE_OFF);
      case ($urandom_range(0, 9))
        0: write_reg(CfgIdxCount, 32'd0);
        1: write_reg(CfgIdxCount, 32'hFFFF_FFFF);
        2: write_reg(CfgIdxCount, $urandom_range(31, 33));
        3: write_reg(CfgIdxCount, $urandom());
        default: write_reg(CfgIdxCount, $urandom_range(1, 80));
      endcase
      if (sh_mode == MODE_Q8 && $urandom_range(0, 4) != 0) begin
        // Well-formed blocks: quants, then the two scale bytes.
        repeat ($urandom_range(1, 3)) begin
          blk = weights_remaining();
          if (blk > BlockWeights) blk = BlockWeights;
          repeat (blk + 2) feed_byte($urandom_range(0, 255));
        end
      end else begin
        nbytes = $urandom_range(1, 24);
        repeat (nbytes) feed_byte($urandom_range(0, 255));
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_weights.size() > 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    errors += pending_weights.size();
    $display("Fed %0d weight bytes in F32, F16 and Q8_0 modes; checked %0d weights.",
             bytes_fed, weights_seen);
    $display("Mismatches: %0d in %0d cycles.", errors, cycles);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
